// ===== hdl/drt_pkg.sv =====
`default_nettype none

package drt_pkg;

    localparam int DEF_MAX_DIM = 2048;
    localparam int COORD_W     = 12;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [1:0] ACT_DAMAGE = 2'd0;
    localparam logic [1:0] ACT_ALL    = 2'd1;
    localparam logic [1:0] ACT_FLIP   = 2'd2;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [COORD_W-1:0] RST_WIDTH  = 12'd2048;
    localparam logic [COORD_W-1:0] RST_HEIGHT = 12'd2048;

    typedef struct packed {
        logic               enable;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } t_item;

    typedef struct packed {
        logic               copy_valid;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_bottom;
        logic               pending;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/drt_cfg.sv =====
`default_nettype none

module drt_cfg
    import drt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (paddr[3:2])
                REG_ENABLE: n_cfg.enable = pwdata[0];
                REG_WIDTH:  n_cfg.width  = pwdata[COORD_W-1:0];
                REG_HEIGHT: n_cfg.height = pwdata[COORD_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b0;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, r_cfg.enable};
            REG_WIDTH:  prdata = {{(DATA_W-COORD_W){1'b0}}, r_cfg.width};
            REG_HEIGHT: prdata = {{(DATA_W-COORD_W){1'b0}}, r_cfg.height};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/drt_update.sv =====
`default_nettype none

module drt_update
    import drt_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    // One bit wider than a coordinate so that a bound of 4096 still compares.
    localparam logic [COORD_W:0] MaxDim = (COORD_W+1)'(MAX_DIM);

    logic               r_dirty;
    logic [COORD_W-1:0] r_left, r_top, r_right, r_bottom;
    logic               n_dirty;
    logic [COORD_W-1:0] n_left, n_top, n_right, n_bottom;
    logic               w_copy;
    logic [COORD_W-1:0] w_w, w_h, w_x1, w_y1;

    assign w_w = ({1'b0, i_cfg.width} > MaxDim) ? MaxDim[COORD_W-1:0] : i_cfg.width;
    assign w_h = ({1'b0, i_cfg.height} > MaxDim) ? MaxDim[COORD_W-1:0] : i_cfg.height;
    assign w_x1 = (i_item.right > w_w) ? w_w : i_item.right;
    assign w_y1 = (i_item.bottom > w_h) ? w_h : i_item.bottom;

    always_comb begin
        n_dirty  = r_dirty;
        n_left   = r_left;
        n_top    = r_top;
        n_right  = r_right;
        n_bottom = r_bottom;
        w_copy   = 1'b0;
        if (i_cfg.enable) begin
            case (i_item.action)
                ACT_DAMAGE: begin
                    // Drop rectangles that start off-screen or are empty after clipping.
                    if (i_item.left < w_w && i_item.top < w_h &&
                        i_item.left < w_x1 && i_item.top < w_y1) begin
                        n_dirty = 1'b1;
                        if (!r_dirty) begin
                            n_left   = i_item.left;
                            n_top    = i_item.top;
                            n_right  = w_x1;
                            n_bottom = w_y1;
                        end else begin
                            if (i_item.left < r_left) n_left = i_item.left;
                            if (i_item.top < r_top) n_top = i_item.top;
                            if (w_x1 > r_right) n_right = w_x1;
                            if (w_y1 > r_bottom) n_bottom = w_y1;
                        end
                    end
                end
                ACT_ALL: begin
                    n_dirty  = 1'b1;
                    n_left   = '0;
                    n_top    = '0;
                    n_right  = w_w;
                    n_bottom = w_h;
                end
                ACT_FLIP: begin
                    if (r_dirty) begin
                        w_copy  = 1'b1;
                        n_dirty = 1'b0;
                    end
                end
                default: w_copy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty  <= 1'b0;
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
        end else if (i_fire) begin
            r_dirty  <= n_dirty;
            r_left   <= n_left;
            r_top    <= n_top;
            r_right  <= n_right;
            r_bottom <= n_bottom;
        end
    end

    assign o_result.copy_valid = w_copy;
    assign o_result.box_left   = n_left;
    assign o_result.box_top    = n_top;
    assign o_result.box_right  = n_right;
    assign o_result.box_bottom = n_bottom;
    assign o_result.pending    = n_dirty;

endmodule

`default_nettype wire

// ===== hdl/damage_rect_tracker.sv =====
// An accepted request is held in the input register, then its result is registered in
// the result register and held there until taken. Throughput: one request per cycle
// unless the output stalls; the box update is a single compare-and-select pass on the
// four region registers between the input and result registers.
// Reset: synchronous, active low; clears the dirty mark, region and valid flags, disables
// the block and sets the screen size to 2048 by 2048.
`default_nettype none

module damage_rect_tracker
    import drt_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic [COORD_W-1:0] i_left,
    input  wire logic [COORD_W-1:0] i_top,
    input  wire logic [COORD_W-1:0] i_right,
    input  wire logic [COORD_W-1:0] i_bottom,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_copy_valid,
    output logic      [COORD_W-1:0] o_box_left,
    output logic      [COORD_W-1:0] o_box_top,
    output logic      [COORD_W-1:0] o_box_right,
    output logic      [COORD_W-1:0] o_box_bottom,
    output logic                    o_pending
);

    t_cfg    w_cfg;
    t_item   r_item;
    t_result w_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_fire;
    logic    w_accept;

    drt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The staged request moves on whenever the result register is free or being taken.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    drt_update #(
        .MAX_DIM (MAX_DIM)
    ) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action <= i_action;
            r_item.left   <= i_left;
            r_item.top    <= i_top;
            r_item.right  <= i_right;
            r_item.bottom <= i_bottom;
        end
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_copy_valid = r_result.copy_valid;
    assign o_box_left   = r_result.box_left;
    assign o_box_top    = r_result.box_top;
    assign o_box_right  = r_result.box_right;
    assign o_box_bottom = r_result.box_bottom;
    assign o_pending    = r_result.pending;

endmodule

`default_nettype wire

// ===== tb/tb_damage_rect_tracker.sv =====
`timescale 1ns / 1ps

module tb_damage_rect_tracker;
    import drt_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_action = ACT_DAMAGE;
    logic [COORD_W-1:0] i_left = '0;
    logic [COORD_W-1:0] i_top = '0;
    logic [COORD_W-1:0] i_right = '0;
    logic [COORD_W-1:0] i_bottom = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_copy_valid;
    logic [COORD_W-1:0] o_box_left;
    logic [COORD_W-1:0] o_box_top;
    logic [COORD_W-1:0] o_box_right;
    logic [COORD_W-1:0] o_box_bottom;
    logic               o_pending;

    damage_rect_tracker DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_left       (i_left),
        .i_top        (i_top),
        .i_right      (i_right),
        .i_bottom     (i_bottom),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_copy_valid (o_copy_valid),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_right  (o_box_right),
        .o_box_bottom (o_box_bottom),
        .o_pending    (o_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration and of the tracked region.
    logic               m_enable = 1'b0;
    logic [COORD_W-1:0] m_width  = RST_WIDTH;
    logic [COORD_W-1:0] m_height = RST_HEIGHT;
    logic               m_dirty  = 1'b0;
    logic [COORD_W-1:0] m_left   = '0;
    logic [COORD_W-1:0] m_top    = '0;
    logic [COORD_W-1:0] m_right  = '0;
    logic [COORD_W-1:0] m_bottom = '0;

    t_item   req_q[$];
    t_result box_q[$];
    int      err_cnt = 0;
    bit      idle_on = 1'b1;
    int      send_gap = 0;
    int      recv_gap = 0;

    function automatic int clip_dim(logic [COORD_W-1:0] dim);
        return (dim > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(dim);
    endfunction

    // Applies one request to the shadow region and returns the result it causes.
    function automatic t_result track_damage(t_item it);
        t_result r;
        int      w;
        int      h;
        int      x1;
        int      y1;
        w = clip_dim(m_width);
        h = clip_dim(m_height);
        r.copy_valid = 1'b0;
        if (m_enable) begin
            case (it.action)
                ACT_DAMAGE: begin
                    x1 = (int'(it.right) > w) ? w : int'(it.right);
                    y1 = (int'(it.bottom) > h) ? h : int'(it.bottom);
                    if (int'(it.left) < w && int'(it.top) < h &&
                        int'(it.left) < x1 && int'(it.top) < y1) begin
                        if (!m_dirty) begin
                            m_left   = it.left;
                            m_top    = it.top;
                            m_right  = 12'(x1);
                            m_bottom = 12'(y1);
                            m_dirty  = 1'b1;
                        end else begin
                            if (it.left < m_left) m_left = it.left;
                            if (it.top < m_top) m_top = it.top;
                            if (x1 > int'(m_right)) m_right = 12'(x1);
                            if (y1 > int'(m_bottom)) m_bottom = 12'(y1);
                        end
                    end
                end
                ACT_ALL: begin
                    m_left   = '0;
                    m_top    = '0;
                    m_right  = 12'(w);
                    m_bottom = 12'(h);
                    m_dirty  = 1'b1;
                end
                ACT_FLIP: begin
                    if (m_dirty) begin
                        r.copy_valid = 1'b1;
                        m_dirty = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        r.box_left   = m_left;
        r.box_top    = m_top;
        r.box_right  = m_right;
        r.box_bottom = m_bottom;
        r.pending    = m_dirty;
        return r;
    endfunction

    // Request driver: predicts at acceptance, then presents the next request.
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                it = '{action: i_action, left: i_left, top: i_top,
                       right: i_right, bottom: i_bottom};
                box_q.push_back(track_damage(it));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (req_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 4) == 0) begin
                    send_gap <= $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else begin
                    it = req_q.pop_front();
                    i_action   <= it.action;
                    i_left     <= it.left;
                    i_top      <= it.top;
                    i_right    <= it.right;
                    i_bottom   <= it.bottom;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (box_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual box %0d %0d %0d %0d",
                             $time, o_box_left, o_box_top, o_box_right, o_box_bottom);
                end else begin
                    exp_r = box_q.pop_front();
                    check_field("copy_valid", exp_r.copy_valid, o_copy_valid);
                    check_field("box_left", exp_r.box_left, o_box_left);
                    check_field("box_top", exp_r.box_top, o_box_top);
                    check_field("box_right", exp_r.box_right, o_box_right);
                    check_field("box_bottom", exp_r.box_bottom, o_box_bottom);
                    check_field("pending", exp_r.pending, o_pending);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                recv_gap <= $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_req(logic [1:0] act, int l, int t, int r, int b);
        t_item it;
        it = '{action: act, left: 12'(l), top: 12'(t), right: 12'(r), bottom: 12'(b)};
        req_q.push_back(it);
    endtask

    // Waits until every request has been taken and answered, then lets the pipeline settle.
    task automatic wait_drained();
        while (req_q.size() != 0 || i_in_valid || box_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [COORD_W-1:0] val);
        logic [DATA_W-1:0] word;
        // Bits above the register width carry noise that the block must drop.
        word = {20'($urandom), val};
        if (idx == REG_ENABLE) word[COORD_W-1:1] = 11'($urandom);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE: m_enable = val[0];
            REG_WIDTH:  m_width  = val;
            REG_HEIGHT: m_height = val;
            default: ;
        endcase
    endtask

    task automatic push_random(int count);
        int w;
        int h;
        int sel;
        int l;
        int t;
        repeat (count) begin
            w = clip_dim(m_width);
            h = clip_dim(m_height);
            sel = $urandom_range(0, 99);
            if (sel < 55 && w > 0 && h > 0) begin
                l = $urandom_range(0, w - 1);
                t = $urandom_range(0, h - 1);
                push_req(ACT_DAMAGE, l, t, $urandom_range(l + 1, w + 8),
                         $urandom_range(t + 1, h + 8));
            end else if (sel < 70) begin
                push_req(ACT_DAMAGE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (sel < 76) begin
                push_req(ACT_ALL, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (sel < 96) begin
                push_req(ACT_FLIP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else begin
                push_req(2'b11, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        int ph_w[8];
        int ph_h[8];
        bit ph_en[8];
        int ph_n[8];
        ph_w  = '{2048, 1, 4095, 640, 0, 1000, 2048, 16};
        ph_h  = '{2048, 1, 4095, 480, 7, 1000, 0, 2048};
        ph_en = '{1, 1, 1, 1, 1, 0, 1, 1};
        ph_n  = '{240, 200, 240, 240, 160, 60, 200, 240};
        ph_w[5] = $urandom_range(1, 4095);
        ph_h[5] = $urandom_range(1, 4095);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the block is disabled, so everything is ignored.
        push_req(ACT_ALL, 0, 0, 0, 0);
        push_req(ACT_DAMAGE, 0, 0, 100, 100);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        wait_drained();

        cfg_write(REG_ENABLE, 12'd1);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        push_req(ACT_DAMAGE, 0, 0, 1, 1);
        push_req(ACT_DAMAGE, 4095, 4095, 4095, 4095);
        push_req(ACT_DAMAGE, 2047, 2047, 4095, 4095);
        push_req(ACT_DAMAGE, 10, 10, 10, 20);
        push_req(ACT_DAMAGE, 30, 40, 20, 50);
        push_req(2'b11, 4095, 4095, 4095, 4095);
        push_req(ACT_FLIP, 4095, 4095, 4095, 4095);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        push_req(ACT_ALL, 4095, 4095, 4095, 4095);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        push_req(ACT_DAMAGE, 100, 200, 300, 400);
        push_req(ACT_DAMAGE, 50, 250, 350, 300);
        push_req(ACT_DAMAGE, 2048, 0, 4095, 10);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        wait_drained();

        // An empty screen drops all rectangles but still takes damage-all.
        cfg_write(REG_WIDTH, 12'd0);
        push_req(ACT_DAMAGE, 0, 0, 1, 1);
        push_req(ACT_ALL, 0, 0, 0, 0);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        wait_drained();
        cfg_write(REG_WIDTH, 12'd4095);
        cfg_write(REG_HEIGHT, 12'd4095);
        push_req(ACT_ALL, 0, 0, 0, 0);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        push_req(ACT_DAMAGE, 2047, 0, 4095, 4095);
        wait_drained();
        cfg_write(REG_ENABLE, 12'd0);
        push_req(ACT_DAMAGE, 0, 0, 5, 5);
        push_req(ACT_FLIP, 0, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            if (p == 7) idle_on = 1'b0;
            cfg_write(REG_WIDTH, 12'(ph_w[p]));
            cfg_write(REG_HEIGHT, 12'(ph_h[p]));
            cfg_write(REG_ENABLE, 12'(ph_en[p]));
            push_random(ph_n[p] / 2);
            // Hold the sender back once mid-phase until the results catch up.
            if (p == 2) wait_drained();
            push_random(ph_n[p] - ph_n[p] / 2);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && box_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/drt_pkg.sv
hdl/drt_cfg.sv
hdl/drt_update.sv
hdl/damage_rect_tracker.sv
tb/tb_damage_rect_tracker.sv
